// ----- sv/svpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, fixed-point constants and types of the space-vector PWM
// duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Field widths
  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned MOD_W   = 16;
  localparam int unsigned CMP_W   = 16;
  localparam int unsigned DT_W    = 10;
  localparam int unsigned SINE_W  = 15;
  localparam int unsigned T_W     = 17;  // one active time, worst case
  localparam int unsigned SUM_W   = 18;  // two active times or zero + active

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 104;

  // Configuration
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME    = 2'd1;
  localparam logic [CMP_W-1:0] TIMER_PERIOD_RST = 16'd1000;
  localparam logic [DT_W-1:0]  DEAD_TIME_RST    = 10'd10;

  // Angle geometry in tenths of a degree
  localparam logic [ANGLE_W-1:0] FULL_TURN_TENTHS = 12'd3600;
  localparam logic [ANGLE_W-1:0] SECTOR_TENTHS    = 12'd600;

  // Sine table and scaling
  localparam int unsigned SINE_ENTRIES_DEF = 1024;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [SINE_W-1:0] K0866_Q15 = 15'd28378;
  // ceil(2^32 / 900): exact floor(n / 900) for n below 41 million
  localparam logic [31:0] QUARTER_RECIP = 32'd4772186;
  localparam int unsigned QUARTER_SHIFT = 32;
  localparam int unsigned ACT_SHIFT = 45;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  // Result beat, last field in the lowest bits
  typedef struct packed {
    logic [3:0]       pad;
    logic             overmodulated;
    logic [2:0]       sector;
    logic [CMP_W-1:0] c_low_compare;
    logic [CMP_W-1:0] c_high_compare;
    logic [CMP_W-1:0] b_low_compare;
    logic [CMP_W-1:0] b_high_compare;
    logic [CMP_W-1:0] a_low_compare;
    logic [CMP_W-1:0] a_high_compare;
  } out_beat_t;

endpackage

// ----- sv/svpwm_duty_with_dead_time.sv -----
// ----------------------------------------------------------------------------
// svpwm_duty_with_dead_time
// Space-vector PWM duty generator with dead time, seven-segment pattern.
// ----------------------------------------------------------------------------
// Each input beat carries an angle in tenths of a degree and a Q1.15
// modulation depth; each output beat carries the six phase compares, the
// sector and an overmodulation flag. The block is a seven-stage pipeline:
// a new beat is taken every cycle unless backpressure has filled every
// stage. The depth is set by the registered sine ROM read and by
// splitting the period x depth x sine x 0.866 product over multiplier
// stages. Backpressure stalls only the stages that are full, so input
// beats are still taken while a result waits at the output. Write
// the timer period and dead time registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module svpwm_duty_with_dead_time #(
  parameter int unsigned SINE_ENTRIES = svpwm_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [11:0] angle_tenths, [27:12] modulation, [31:28] zero
  input  logic [svpwm_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // Output stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [15:0] a_high_compare, [31:16] a_low_compare, [47:32] b_high_compare,
  // [63:48] b_low_compare, [79:64] c_high_compare, [95:80] c_low_compare,
  // [98:96] sector, [99] overmodulated, [103:100] zero
  output logic [svpwm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import svpwm_pkg::*;

  localparam int unsigned IDX_W = $clog2(SINE_ENTRIES);
  localparam logic [47:0] IdxMul = 48'(SINE_ENTRIES) * 48'(QUARTER_RECIP);
  localparam logic [15:0] IdxMax = 16'(SINE_ENTRIES - 1);
  localparam logic [ANGLE_W-1:0] Sec2Base = 12'd1200;
  localparam logic [ANGLE_W-1:0] Sec3Base = 12'd1800;
  localparam logic [ANGLE_W-1:0] Sec4Base = 12'd2400;
  localparam logic [ANGLE_W-1:0] Sec5Base = 12'd3000;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] period_q;
  logic [DT_W-1:0]  dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= TIMER_PERIOD_RST;
      dead_q   <= DEAD_TIME_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TIMER_PERIOD) begin
        period_q <= cfg_data_i[CMP_W-1:0];
      end else if (cfg_idx_i == REG_DEAD_TIME) begin
        dead_q <= cfg_data_i[DT_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids and ready chain
  // --------------------------------------------------------------------------
  logic [7:1] v_q;
  logic [7:1] rdy;
  logic [7:1] ld;

  always_comb begin
    rdy[7] = !v_q[7] || m_axis_tready_i;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ld[1] = rdy[1] && s_axis_tvalid_i;
    for (int k = 2; k <= 7; k++) begin
      ld[k] = rdy[k] && v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = rdy[1];

  // --------------------------------------------------------------------------
  // Stage 1: wrap the angle, find sector and offset
  // --------------------------------------------------------------------------
  logic [ANGLE_W-1:0] ang_in;
  logic [ANGLE_W-1:0] ang_w;
  logic [ANGLE_W-1:0] sec_base;
  logic [ANGLE_W-1:0] off_w;
  sector_e            sec_d;

  sector_e         sec1_q;
  logic [9:0]      off1_q;
  logic [MOD_W-1:0] mod1_q;

  always_comb begin
    ang_in = s_axis_tdata_i[ANGLE_W-1:0];
    ang_w  = (ang_in >= FULL_TURN_TENTHS) ? ang_in - FULL_TURN_TENTHS : ang_in;
    if (ang_w >= Sec5Base) begin
      sec_d = SEC_5; sec_base = Sec5Base;
    end else if (ang_w >= Sec4Base) begin
      sec_d = SEC_4; sec_base = Sec4Base;
    end else if (ang_w >= Sec3Base) begin
      sec_d = SEC_3; sec_base = Sec3Base;
    end else if (ang_w >= Sec2Base) begin
      sec_d = SEC_2; sec_base = Sec2Base;
    end else if (ang_w >= SECTOR_TENTHS) begin
      sec_d = SEC_1; sec_base = SECTOR_TENTHS;
    end else begin
      sec_d = SEC_0; sec_base = '0;
    end
    off_w = ang_w - sec_base;
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sec1_q <= sec_d;
      off1_q <= off_w[9:0];
      mod1_q <= s_axis_tdata_i[ANGLE_W +: MOD_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: table indexes floor(x * SINE_ENTRIES / 900), period x depth
  // --------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] sine_index(input logic [9:0] x);
    logic [47:0] prod;
    logic [15:0] q;
    prod = 48'(x) * IdxMul;
    q    = prod[QUARTER_SHIFT +: 16];
    return (q > IdxMax) ? IdxMax[IDX_W-1:0] : q[IDX_W-1:0];
  endfunction

  logic [9:0] x_t1;

  sector_e          sec2_q;
  logic [IDX_W-1:0] idx_t1_2_q;
  logic [IDX_W-1:0] idx_t2_2_q;
  logic [31:0]      pm2_q;

  assign x_t1 = SECTOR_TENTHS[9:0] - off1_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      sec2_q     <= sec1_q;
      idx_t1_2_q <= sine_index(x_t1);
      idx_t2_2_q <= sine_index(off1_q);
      pm2_q      <= 32'(period_q) * 32'(mod1_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sine ROM read
  // --------------------------------------------------------------------------
  logic [SINE_W-1:0] sin_t1_3;
  logic [SINE_W-1:0] sin_t2_3;
  sector_e           sec3_q;
  logic [31:0]       pm3_q;

  svpwm_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (ld[3]),
    .addr_a_i(idx_t1_2_q),
    .addr_b_i(idx_t2_2_q),
    .data_a_o(sin_t1_3),
    .data_b_o(sin_t2_3)
  );

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      sec3_q <= sec2_q;
      pm3_q  <= pm2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale sines by 0.866
  // --------------------------------------------------------------------------
  sector_e     sec4_q;
  logic [31:0] pm4_q;
  logic [29:0] sk1_4_q;
  logic [29:0] sk2_4_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      sec4_q  <= sec3_q;
      pm4_q   <= pm3_q;
      sk1_4_q <= 30'(sin_t1_3) * 30'(K0866_Q15);
      sk2_4_q <= 30'(sin_t2_3) * 30'(K0866_Q15);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: active times, truncated
  // --------------------------------------------------------------------------
  logic [61:0] prod_t1;
  logic [61:0] prod_t2;

  sector_e        sec5_q;
  logic [T_W-1:0] t1_5_q;
  logic [T_W-1:0] t2_5_q;

  assign prod_t1 = 62'(pm4_q) * 62'(sk1_4_q);
  assign prod_t2 = 62'(pm4_q) * 62'(sk2_4_q);

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      sec5_q <= sec4_q;
      t1_5_q <= prod_t1[ACT_SHIFT +: T_W];
      t2_5_q <= prod_t2[ACT_SHIFT +: T_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: zero time, overmodulation, segment edges
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] act_sum;
  logic             over_d;
  logic [SUM_W-1:0] rest;
  logic [CMP_W-1:0] t0_d;

  sector_e          sec6_q;
  logic             over6_q;
  logic [CMP_W-1:0] t0_6_q;
  logic [CMP_W-1:0] full6_q;
  logic [SUM_W-1:0] s01_6_q;
  logic [SUM_W-1:0] s02_6_q;

  always_comb begin
    act_sum = SUM_W'(t1_5_q) + SUM_W'(t2_5_q);
    over_d  = act_sum > SUM_W'(period_q);
    rest    = SUM_W'(period_q) - act_sum;
    t0_d    = over_d ? '0 : (rest[CMP_W-1:0] >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      sec6_q  <= sec5_q;
      over6_q <= over_d;
      t0_6_q  <= t0_d;
      full6_q <= period_q - t0_d;
      s01_6_q <= SUM_W'(t0_d) + SUM_W'(t1_5_q);
      s02_6_q <= SUM_W'(t0_d) + SUM_W'(t2_5_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: per-sector assignment, clamp, dead time, output register
  // --------------------------------------------------------------------------
  function automatic logic [CMP_W-1:0] clamp_p(input logic [SUM_W-1:0] v,
                                                input logic [CMP_W-1:0] p);
    return (v > SUM_W'(p)) ? p : v[CMP_W-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] high_side(input logic [CMP_W-1:0] lo,
                                                  input logic [DT_W-1:0]  dt);
    return (lo > CMP_W'(dt)) ? lo - CMP_W'(dt) : '0;
  endfunction

  logic [SUM_W-1:0] lo_a;
  logic [SUM_W-1:0] lo_b;
  logic [SUM_W-1:0] lo_c;
  logic [SUM_W-1:0] full_x;
  logic [SUM_W-1:0] t0_x;
  logic [CMP_W-1:0] lo_a_c;
  logic [CMP_W-1:0] lo_b_c;
  logic [CMP_W-1:0] lo_c_c;
  out_beat_t        out_d;
  out_beat_t        out_q;

  always_comb begin
    full_x = SUM_W'(full6_q);
    t0_x   = SUM_W'(t0_6_q);
    case (sec6_q)
      SEC_0: begin lo_a = full_x;  lo_b = s02_6_q; lo_c = t0_x;    end
      SEC_1: begin lo_b = full_x;  lo_a = s01_6_q; lo_c = t0_x;    end
      SEC_2: begin lo_b = full_x;  lo_c = s02_6_q; lo_a = t0_x;    end
      SEC_3: begin lo_c = full_x;  lo_b = s01_6_q; lo_a = t0_x;    end
      SEC_4: begin lo_c = full_x;  lo_a = s02_6_q; lo_b = t0_x;    end
      default: begin lo_a = full_x; lo_c = s01_6_q; lo_b = t0_x;   end
    endcase
    lo_a_c = clamp_p(lo_a, period_q);
    lo_b_c = clamp_p(lo_b, period_q);
    lo_c_c = clamp_p(lo_c, period_q);

    out_d.pad            = '0;
    out_d.overmodulated  = over6_q;
    out_d.sector         = sec6_q;
    out_d.a_low_compare  = lo_a_c;
    out_d.a_high_compare = high_side(lo_a_c, dead_q);
    out_d.b_low_compare  = lo_b_c;
    out_d.b_high_compare = high_side(lo_b_c, dead_q);
    out_d.c_low_compare  = lo_c_c;
    out_d.c_high_compare = high_side(lo_c_c, dead_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = v_q[7];
  assign m_axis_tdata_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input side stalls only when a result is held at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a held output beat");

  // High-side compare never exceeds its low-side compare
  a_high_below_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.a_high_compare <= out_q.a_low_compare &&
                         out_q.b_high_compare <= out_q.b_low_compare &&
                         out_q.c_high_compare <= out_q.c_low_compare))
    else $error("high-side compare above low-side compare");

  // A held result stays put while the pipeline behind it keeps filling
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(out_q))
    else $error("held output beat changed");

endmodule

// ----- sv/svpwm_sine_rom.sv -----
// ----------------------------------------------------------------------------
// svpwm_sine_rom
// Quarter-wave sine ROM in Q1.15 with two registered read ports. Entry i holds
// sin(i * 90 deg / SINE_ENTRIES), built at elaboration from a Taylor series.
// ----------------------------------------------------------------------------
module svpwm_sine_rom #(
  parameter int unsigned SINE_ENTRIES = svpwm_pkg::SINE_ENTRIES_DEF,
  parameter int unsigned IDX_W        = $clog2(SINE_ENTRIES)
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [IDX_W-1:0]          addr_a_i,
  input  logic [IDX_W-1:0]          addr_b_i,
  output logic [svpwm_pkg::SINE_W-1:0] data_a_o,
  output logic [svpwm_pkg::SINE_W-1:0] data_b_o
);
  import svpwm_pkg::*;

  typedef logic [SINE_W-1:0] rom_t [SINE_ENTRIES];

  // Evaluate sin(x) in Q30 with seven series terms, round to Q15 and cap
  function automatic rom_t build_rom();
    rom_t              rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic [63:0]       r;
    logic signed [63:0] sum;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = (unsigned'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      rom[i] = r[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [SINE_W-1:0] data_a_q;
  logic [SINE_W-1:0] data_b_q;

  // Read both ports, hold while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SineRom[addr_a_i];
      data_b_q <= SineRom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule
